/* src/pmd_pkg.sv */
// ----------------------------------------------------------------------------
// pmd_pkg
// Shared types and constants for the preamble/length message deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package pmd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 4 * ByteW;

  localparam logic [WordW-1:0] PreambleReset = 32'hAA55_C33C;

  localparam logic [ByteW-1:0] MinLength  = 8'd2;
  localparam logic [ByteW-1:0] LengthPos  = 8'd1;
  localparam logic [ByteW-1:0] FirstPayld = 8'd2;

  typedef enum logic [2:0] {
    PH_PRE0    = 3'd0,
    PH_PRE1    = 3'd1,
    PH_PRE2    = 3'd2,
    PH_PRE3    = 3'd3,
    PH_ID      = 3'd4,
    PH_LENGTH  = 3'd5,
    PH_PAYLOAD = 3'd6
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] message_id;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] byte_position;
    logic             last_of_message;
    logic             bad_length;
  } result_t;

endpackage

`default_nettype wire

/* src/pmd_in_stage.sv */
// ----------------------------------------------------------------------------
// pmd_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_in_stage (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [pmd_pkg::ByteW-1:0] rx_byte_i,
  input  wire logic                      take_i,
  output logic                           valid_o,
  output logic      [pmd_pkg::ByteW-1:0] byte_o
);
  import pmd_pkg::*;

  logic             valid_q;
  logic [ByteW-1:0] byte_q;

  // Accept a new byte when empty or when the held byte leaves this cycle.
  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

/* src/pmd_parser.sv */
// ----------------------------------------------------------------------------
// pmd_parser
// Frame state machine: preamble hunt, id and length capture, payload count.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_parser (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [pmd_pkg::WordW-1:0] preamble_i,
  input  wire logic [pmd_pkg::ByteW-1:0] byte_i,
  input  wire logic                      step_i,
  output logic                           has_result_o,
  output pmd_pkg::result_t               result_o
);
  import pmd_pkg::*;

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] id_q, id_d;
  logic [ByteW-1:0] exp_len_q, exp_len_d;
  logic [ByteW-1:0] count_q, count_d;
  logic [ByteW-1:0] want;
  logic             last_pay;

  // pos + 1 >= length, done one bit wider to avoid wrap
  assign last_pay = ({1'b0, count_q} + 9'd1) >= {1'b0, exp_len_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_PRE0;
      id_q      <= '0;
      exp_len_q <= '0;
      count_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      id_q      <= id_d;
      exp_len_q <= exp_len_d;
      count_q   <= count_d;
    end
  end

  always_comb begin
    phase_d      = phase_q;
    id_d         = id_q;
    exp_len_d    = exp_len_q;
    count_d      = count_q;
    has_result_o = 1'b0;
    want         = preamble_i[WordW-1 -: ByteW];
    result_o     = '{message_id: id_q, data_byte: byte_i, byte_position: LengthPos,
                     last_of_message: 1'b0, bad_length: 1'b0};
    unique case (phase_q)
      PH_PRE0, PH_PRE1, PH_PRE2, PH_PRE3: begin
        unique case (phase_q)
          PH_PRE1: want = preamble_i[3*ByteW-1 -: ByteW];
          PH_PRE2: want = preamble_i[2*ByteW-1 -: ByteW];
          PH_PRE3: want = preamble_i[ByteW-1 -: ByteW];
          default: want = preamble_i[WordW-1 -: ByteW];
        endcase
        phase_d = (byte_i == want) ? phase_e'(phase_q + 3'd1) : PH_PRE0;
      end
      PH_ID: begin
        id_d    = byte_i;
        phase_d = PH_LENGTH;
      end
      PH_LENGTH: begin
        has_result_o = 1'b1;
        if (byte_i <= MinLength) begin
          // short or empty frame: report and hunt again
          result_o.bad_length      = byte_i < MinLength;
          result_o.last_of_message = byte_i == MinLength;
          phase_d   = PH_PRE0;
          exp_len_d = '0;
          count_d   = '0;
        end else begin
          exp_len_d = byte_i;
          count_d   = FirstPayld;
          phase_d   = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        has_result_o             = 1'b1;
        result_o.byte_position   = count_q;
        result_o.last_of_message = last_pay;
        if (last_pay) begin
          phase_d   = PH_PRE0;
          exp_len_d = '0;
          count_d   = '0;
        end else begin
          count_d = count_q + 8'd1;
        end
      end
      default: begin
        // unused phase code acts as the first preamble byte
        phase_d = (byte_i == want) ? PH_PRE1 : PH_PRE0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/pmd_out_stage.sv */
// ----------------------------------------------------------------------------
// pmd_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pmd_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire pmd_pkg::result_t result_i,
  output logic                  can_take_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output pmd_pkg::result_t      result_o
);
  import pmd_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign can_take_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

/* src/preamble_length_message_deframer.sv */
// ----------------------------------------------------------------------------
// preamble_length_message_deframer
// Hunts a four-byte preamble, then emits the length and payload bytes of
// each id/length-prefixed message.
// ----------------------------------------------------------------------------
// One received byte per cycle is sustained while the downstream side keeps
// out_ready high: a byte is held in the input register, the frame state
// machine decides on it in the cycle it is held, and its result (if any)
// appears in the result register the cycle after. Preamble and id bytes give no result; the
// length byte and every payload byte give one. A length below two yields a
// result with bad_length set and the preamble hunt starts over. The
// preamble register may be rewritten at any time the block is idle.
`default_nettype none

module preamble_length_message_deframer (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [pmd_pkg::WordW-1:0] cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [pmd_pkg::ByteW-1:0] rx_byte_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [pmd_pkg::ByteW-1:0] message_id_o,
  output logic      [pmd_pkg::ByteW-1:0] data_byte_o,
  output logic      [pmd_pkg::ByteW-1:0] byte_position_o,
  output logic                           last_of_message_o,
  output logic                           bad_length_o
);
  import pmd_pkg::*;

  logic [WordW-1:0] preamble_q;
  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             has_result;
  logic             can_take;
  logic             step;
  result_t          res_new;
  result_t          res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q <= PreambleReset;
    end else if (cfg_we_i) begin
      preamble_q <= cfg_wdata_i;
    end
  end

  // Advance the held byte unless it has a result and the result slot is full.
  assign step = held_valid && (!has_result || can_take);

  pmd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (step),
    .valid_o    (held_valid),
    .byte_o     (held_byte)
  );

  pmd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .preamble_i   (preamble_q),
    .byte_i       (held_byte),
    .step_i       (step),
    .has_result_o (has_result),
    .result_o     (res_new)
  );

  pmd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && has_result),
    .result_i    (res_new),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (res_out)
  );

  assign message_id_o      = res_out.message_id;
  assign data_byte_o       = res_out.data_byte;
  assign byte_position_o   = res_out.byte_position;
  assign last_of_message_o = res_out.last_of_message;
  assign bad_length_o      = res_out.bad_length;

  // A dropped frame is never also flagged as complete, and sits at the length slot.
  a_bad_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_length_o |->
      !last_of_message_o && byte_position_o == LengthPos && data_byte_o < MinLength)
    else $error("bad_length result malformed");

  // Never advance a byte with a result into a full result slot.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid && has_result && !can_take |-> !step)
    else $error("result register overwritten");

  // Payload positions lie beyond the length byte.
  a_pos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_length_o && byte_position_o != LengthPos |->
      byte_position_o >= FirstPayld && byte_position_o != 8'd255)
    else $error("payload position out of range");

endmodule

`default_nettype wire
